@@ rtl/mpf_pkg.sv @@
// ----------------------------------------------------------------------------
// mpf_pkg
// Types and constants shared by the PUBLISH framer modules.
// ----------------------------------------------------------------------------
package mpf_pkg;

    localparam int JOB_BYTES = 8;
    localparam int CNT_W     = $clog2(JOB_BYTES + 1);
    localparam int Q_DEPTH   = 4;
    localparam int QA_W      = $clog2(Q_DEPTH);
    localparam int QC_W      = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_TOPIC   = 2'd1;
    localparam logic [1:0] CMD_PAYLOAD = 2'd2;

    localparam logic [7:0] HDR_PUBLISH = 8'h30;
    localparam logic [7:0] PID_HI      = 8'h00;
    localparam logic [7:0] PID_LO      = 8'h01;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  data_byte;
        logic [15:0] topic_length;
        logic [15:0] payload_length;
        logic [1:0]  qos;
        logic        retain;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       too_long;
    } t_out_item;

    // One queued run of output bytes; slot 0 goes out first.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      last;
        logic                      too_long;
    } t_job;

endpackage

@@ rtl/mpf_front.sv @@
// ----------------------------------------------------------------------------
// mpf_front
// Accepts requests, tracks packet phase and turns each start, topic or
// payload request that fits the phase into an output byte run for the queue.
// ----------------------------------------------------------------------------
module mpf_front
    import mpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_item    i_in_item,
    output logic        o_stall,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_TOPIC   = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DROP    = 2'd3;

    logic [15:0] r_max;
    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_topic_left, n_topic_left;
    logic [15:0] r_payload_left, n_payload_left;
    logic        r_need_pid, n_need_pid;

    logic        w_accept;
    logic [17:0] w_rem;
    logic [17:0] w_total;
    logic [1:0]  w_nb;
    logic        w_qos_nz;
    logic [7:0]  w_hdr;
    logic [7:0]  w_rl0, w_rl1, w_rl2;
    logic [15:0] w_topic_next;
    logic [15:0] w_payload_next;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_qos_nz = (i_in_item.qos != 2'd0);

    assign w_rem   = 18'(i_in_item.topic_length) + 18'(i_in_item.payload_length)
                   + (w_qos_nz ? 18'd4 : 18'd2);
    assign w_nb    = (w_rem < 18'd128) ? 2'd1 : ((w_rem < 18'd16384) ? 2'd2 : 2'd3);
    assign w_total = w_rem + 18'd1 + 18'(w_nb);

    assign w_hdr = HDR_PUBLISH | {5'd0, i_in_item.qos, 1'b0} | {7'd0, i_in_item.retain};
    assign w_rl0 = {(w_nb > 2'd1), w_rem[6:0]};
    assign w_rl1 = {(w_nb > 2'd2), w_rem[13:7]};
    assign w_rl2 = {4'd0, w_rem[17:14]};

    assign w_topic_next   = r_topic_left - 16'd1;
    assign w_payload_next = r_payload_left - 16'd1;

    always_comb begin
        n_phase        = r_phase;
        n_topic_left   = r_topic_left;
        n_payload_left = r_payload_left;
        n_need_pid     = r_need_pid;
        o_push         = 1'b0;
        o_job          = '0;
        if (w_accept) begin
            case (i_in_item.command)
                CMD_START: begin
                    o_push = 1'b1;
                    if (w_total > 18'(r_max)) begin
                        o_job.count    = CNT_W'(1);
                        o_job.last     = 1'b1;
                        o_job.too_long = 1'b1;
                        n_phase        = PH_DROP;
                        n_topic_left   = 16'd0;
                        n_payload_left = 16'd0;
                        n_need_pid     = 1'b0;
                    end else begin
                        o_job.bytes[0] = w_hdr;
                        o_job.bytes[1] = w_rl0;
                        case (w_nb)
                            2'd1: begin
                                o_job.bytes[2] = i_in_item.topic_length[15:8];
                                o_job.bytes[3] = i_in_item.topic_length[7:0];
                                o_job.bytes[4] = PID_HI;
                                o_job.bytes[5] = PID_LO;
                            end
                            2'd2: begin
                                o_job.bytes[2] = w_rl1;
                                o_job.bytes[3] = i_in_item.topic_length[15:8];
                                o_job.bytes[4] = i_in_item.topic_length[7:0];
                                o_job.bytes[5] = PID_HI;
                                o_job.bytes[6] = PID_LO;
                            end
                            default: begin
                                o_job.bytes[2] = w_rl1;
                                o_job.bytes[3] = w_rl2;
                                o_job.bytes[4] = i_in_item.topic_length[15:8];
                                o_job.bytes[5] = i_in_item.topic_length[7:0];
                                o_job.bytes[6] = PID_HI;
                                o_job.bytes[7] = PID_LO;
                            end
                        endcase
                        n_topic_left   = i_in_item.topic_length;
                        n_payload_left = i_in_item.payload_length;
                        // empty topic: close the topic section in this same run
                        if (i_in_item.topic_length == 16'd0) begin
                            o_job.count = CNT_W'(w_nb) + CNT_W'(3)
                                        + (w_qos_nz ? CNT_W'(2) : CNT_W'(0));
                            o_job.last  = (i_in_item.payload_length == 16'd0);
                            n_need_pid  = 1'b0;
                            n_phase     = (i_in_item.payload_length == 16'd0) ?
                                          PH_IDLE : PH_PAYLOAD;
                        end else begin
                            o_job.count = CNT_W'(w_nb) + CNT_W'(3);
                            n_need_pid  = w_qos_nz;
                            n_phase     = PH_TOPIC;
                        end
                    end
                end
                CMD_TOPIC: begin
                    if (r_phase == PH_TOPIC && r_topic_left != 16'd0) begin
                        o_push         = 1'b1;
                        o_job.bytes[0] = i_in_item.data_byte;
                        o_job.bytes[1] = PID_HI;
                        o_job.bytes[2] = PID_LO;
                        o_job.count    = CNT_W'(1);
                        n_topic_left   = w_topic_next;
                        if (w_topic_next == 16'd0) begin
                            if (r_need_pid) begin
                                o_job.count = CNT_W'(3);
                            end
                            o_job.last = (r_payload_left == 16'd0);
                            n_need_pid = 1'b0;
                            n_phase    = (r_payload_left == 16'd0) ? PH_IDLE : PH_PAYLOAD;
                        end
                    end
                end
                CMD_PAYLOAD: begin
                    if (r_phase == PH_PAYLOAD && r_payload_left != 16'd0) begin
                        o_push         = 1'b1;
                        o_job.bytes[0] = i_in_item.data_byte;
                        o_job.count    = CNT_W'(1);
                        o_job.last     = (w_payload_next == 16'd0);
                        n_payload_left = w_payload_next;
                        if (w_payload_next == 16'd0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                    // drop stray command codes
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max          <= 16'hFFFF;
            r_phase        <= PH_IDLE;
            r_topic_left   <= 16'd0;
            r_payload_left <= 16'd0;
            r_need_pid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            r_phase        <= n_phase;
            r_topic_left   <= n_topic_left;
            r_payload_left <= n_payload_left;
            r_need_pid     <= n_need_pid;
        end
    end

endmodule

@@ rtl/mpf_queue.sv @@
// ----------------------------------------------------------------------------
// mpf_queue
// Short FIFO of byte runs between the request side and the output side.
// ----------------------------------------------------------------------------
module mpf_queue
    import mpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job            r_mem [Q_DEPTH];
    logic [QA_W-1:0] r_wr_ptr;
    logic [QA_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count;

    assign o_full  = (r_count == QC_W'(Q_DEPTH));
    assign o_valid = (r_count != QC_W'(0));
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QA_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QA_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QC_W'(1);
                2'b01:   r_count <= r_count - QC_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/mpf_back.sv @@
// ----------------------------------------------------------------------------
// mpf_back
// Output stage: loads one byte run at a time and shifts it out, one byte per
// request on the result channel.
// ----------------------------------------------------------------------------
module mpf_back
    import mpf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_out_item,
    input  logic      i_stall
);

    logic [JOB_BYTES-1:0][7:0] r_bytes, n_bytes;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_last, n_last;
    logic                      r_too_long, n_too_long;
    logic                      w_take;
    logic                      w_empty_next;

    assign o_valid             = (r_cnt != CNT_W'(0));
    assign w_take              = o_valid && !i_stall;
    assign w_empty_next        = !o_valid || (w_take && r_cnt == CNT_W'(1));
    assign o_pop               = i_q_valid && w_empty_next;
    assign o_out_item.out_byte = r_bytes[0];
    assign o_out_item.last     = r_last && (r_cnt == CNT_W'(1));
    assign o_out_item.too_long = r_too_long;

    always_comb begin
        n_bytes    = r_bytes;
        n_cnt      = r_cnt;
        n_last     = r_last;
        n_too_long = r_too_long;
        if (o_pop) begin
            n_bytes    = i_job.bytes;
            n_cnt      = i_job.count;
            n_last     = i_job.last;
            n_too_long = i_job.too_long;
        end else if (w_take) begin
            // advance to the next byte of the run
            n_bytes = {8'h00, r_bytes[JOB_BYTES-1:1]};
            n_cnt   = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes    <= n_bytes;
        r_last     <= n_last;
        r_too_long <= n_too_long;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/mqtt_publish_framer.sv @@
// ----------------------------------------------------------------------------
// mqtt_publish_framer
// MQTT PUBLISH packet framer: start, topic and payload requests in, packet
// bytes out.
// ----------------------------------------------------------------------------
// A request is taken in every cycle while the four-entry run queue has room;
// its result bytes leave the output shift register one per cycle while
// i_stall is low. A start within the limit yields 4 to 8 bytes (header, 1-3
// length bytes, topic length, and packet id when the topic is empty and QoS
// is nonzero), a topic byte 1 or 3 and a payload byte 1. Streaming topic and
// payload runs at one byte per cycle while neither side stalls; the output
// port's one byte per cycle sets the sustained rate. An oversize start gives
// one byte with last and too_long set and drops all bytes up to the next
// start. max_packet_length is written through i_cfg_wr_en/i_cfg_wr_data.
// ----------------------------------------------------------------------------
module mqtt_publish_framer
    import mpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_item    i_in_item,
    output logic        o_stall,
    output logic        o_valid,
    output t_out_item   o_out_item,
    input  logic        i_stall,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    logic w_q_full;
    logic w_push;
    t_job w_push_job;
    logic w_q_valid;
    t_job w_q_job;
    logic w_pop;

    mpf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_in_item     (i_in_item),
        .o_stall       (o_stall),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    mpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .i_pop   (w_pop)
    );

    mpf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_job      (w_q_job),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .o_out_item (o_out_item),
        .i_stall    (i_stall)
    );

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_item.too_long |-> o_out_item.last && o_out_item.out_byte == 8'h00)
        else $error("rejection result without last or with nonzero byte");

    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_valid)
        else $error("loaded run did not present a byte");

    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid && !o_valid |-> w_pop)
        else $error("queued run left waiting while output idle");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for mqtt_publish_framer. A directed table covers empty
// and maximal packets, the size limit boundary, abandoned packets and stray
// requests. Random PUBLISH request streams then run under several packet
// size limits. The request side idles and the byte side stalls at random.
// Every byte leaving the block is checked against a predicted frame.
// ----------------------------------------------------------------------------
module tb_top;
    import mpf_pkg::*;

    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int unsigned GAP_MAX        = 13;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned QUIET_LIMIT    = 600;
    localparam int unsigned PHASE_REQUESTS = 38;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef enum logic [1:0] {FR_IDLE, FR_TOPIC, FR_PAYLOAD, FR_DROP} t_fr_phase;

    typedef struct {
        t_in_item    req;
        int unsigned n_fixed;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    t_in_item    i_in_item     = '0;
    logic        o_stall;
    logic        o_valid;
    t_out_item   o_out_item;
    logic        i_stall       = 1'b1;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    // framer state as predicted
    t_fr_phase   fr_phase        = FR_IDLE;
    logic [15:0] fr_topic_left   = '0;
    logic [15:0] fr_payload_left = '0;
    logic        fr_pid_owed     = 1'b0;
    logic [15:0] fr_max_len      = 16'hFFFF;

    t_out_item   pending_bytes[$];
    t_out_item   fixed_bytes[$];
    t_dir_row    dir_rows[$];
    int unsigned requests_sent     = 0;
    int unsigned mismatches        = 0;
    int unsigned quiet_cycles      = 0;
    bit          send_burst        = 1'b0;
    bit          recv_burst        = 1'b0;
    t_out_item   want;

    mqtt_publish_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_in_item     (i_in_item),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_out_item    (o_out_item),
        .i_stall       (i_stall),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_out_item pkt_byte(logic [7:0] b, logic last, logic too_long);
        t_out_item r;
        r.out_byte = b;
        r.last     = last;
        r.too_long = too_long;
        return r;
    endfunction

    function automatic t_in_item mk_req(logic [1:0] cmd, logic [7:0] data, logic [15:0] tlen,
                                        logic [15:0] plen, logic [1:0] qos, logic retain);
        t_in_item r;
        r.command        = cmd;
        r.data_byte      = data;
        r.topic_length   = tlen;
        r.payload_length = plen;
        r.qos            = qos;
        r.retain         = retain;
        return r;
    endfunction

    function automatic t_in_item any_request();
        return mk_req(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 16'($urandom),
                      2'($urandom_range(0, 3)), 1'($urandom));
    endfunction

    function automatic void want_byte(logic [7:0] b, logic last, logic too_long);
        fixed_bytes.push_back(pkt_byte(b, last, too_long));
    endfunction

    // Append the packet id where owed; mark last if no payload follows.
    function automatic void close_topic(ref t_out_item res[$]);
        t_out_item tail;
        if (fr_pid_owed) begin
            res.push_back(pkt_byte(PID_HI, 1'b0, 1'b0));
            res.push_back(pkt_byte(PID_LO, 1'b0, 1'b0));
            fr_pid_owed = 1'b0;
        end
        if (fr_payload_left == 16'd0) begin
            tail      = res.pop_back();
            tail.last = 1'b1;
            res.push_back(tail);
            fr_phase  = FR_IDLE;
        end else begin
            fr_phase = FR_PAYLOAD;
        end
    endfunction

    function automatic void frame_request(input t_in_item req, ref t_out_item res[$]);
        int unsigned rem;
        int unsigned nb;
        int unsigned total;
        int unsigned v;
        logic [7:0]  b;
        res.delete();
        if (req.command == CMD_START) begin
            rem = 32'd2 + 32'(req.topic_length) + 32'(req.payload_length)
                + ((req.qos != 2'd0) ? 32'd2 : 32'd0);
            nb    = (rem < 128) ? 1 : ((rem < 16384) ? 2 : 3);
            total = 1 + nb + rem;
            if (total > 32'(fr_max_len)) begin
                res.push_back(pkt_byte(8'h00, 1'b1, 1'b1));
                fr_phase        = FR_DROP;
                fr_topic_left   = '0;
                fr_payload_left = '0;
                fr_pid_owed     = 1'b0;
            end else begin
                res.push_back(pkt_byte(HDR_PUBLISH | {5'd0, req.qos, req.retain}, 1'b0, 1'b0));
                v = rem;
                for (int unsigned i = 0; i < nb; i++) begin
                    b = 8'(v % 128);
                    v = v / 128;
                    if (i + 1 < nb) b = b | 8'h80;
                    res.push_back(pkt_byte(b, 1'b0, 1'b0));
                end
                res.push_back(pkt_byte(req.topic_length[15:8], 1'b0, 1'b0));
                res.push_back(pkt_byte(req.topic_length[7:0], 1'b0, 1'b0));
                fr_topic_left   = req.topic_length;
                fr_payload_left = req.payload_length;
                fr_pid_owed     = (req.qos != 2'd0);
                fr_phase        = FR_TOPIC;
                if (fr_topic_left == 16'd0) close_topic(res);
            end
        end else if (req.command == CMD_TOPIC && fr_phase == FR_TOPIC
                     && fr_topic_left != 16'd0) begin
            res.push_back(pkt_byte(req.data_byte, 1'b0, 1'b0));
            fr_topic_left = fr_topic_left - 16'd1;
            if (fr_topic_left == 16'd0) close_topic(res);
        end else if (req.command == CMD_PAYLOAD && fr_phase == FR_PAYLOAD
                     && fr_payload_left != 16'd0) begin
            fr_payload_left = fr_payload_left - 16'd1;
            res.push_back(pkt_byte(req.data_byte, fr_payload_left == 16'd0, 1'b0));
            if (fr_payload_left == 16'd0) fr_phase = FR_IDLE;
        end
    endfunction

    // Present one request after a random gap and hold it until taken.
    task automatic push_request(input t_in_item req, input int unsigned n_fixed);
        int unsigned gap;
        t_out_item   res[$];
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_item <= req;
        do @(posedge i_clk); while (o_stall);
        frame_request(req, res);
        if (n_fixed != 0) begin
            repeat (n_fixed) pending_bytes.push_back(fixed_bytes.pop_front());
        end else begin
            foreach (res[i]) pending_bytes.push_back(res[i]);
        end
        requests_sent++;
    endtask

    // Hold off until every predicted byte is out, then let the block settle.
    task automatic settle_results();
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_len(input logic [15:0] value);
        settle_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        fr_max_len = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed packets with random content; some noise and cut-offs.
    task automatic random_packet();
        t_in_item    req;
        t_in_item    item;
        int unsigned n_bytes;
        int unsigned cut;
        bit          big;
        req = any_request();
        if ($urandom_range(0, 9) == 0) begin
            push_request(req, 0);
            return;
        end
        big         = ($urandom_range(0, 11) == 0);
        req.command = CMD_START;
        if (!big) begin
            req.topic_length   = 16'($urandom_range(0, 6));
            req.payload_length = 16'($urandom_range(0, 8));
        end
        n_bytes = 32'(req.topic_length) + 32'(req.payload_length);
        push_request(req, 0);
        // abandon large packets early, and a few ordinary ones
        cut = (big || $urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : n_bytes;
        for (int unsigned k = 0; k < n_bytes && k < cut; k++) begin
            item         = any_request();
            item.command = (k < 32'(req.topic_length)) ? CMD_TOPIC : CMD_PAYLOAD;
            if ($urandom_range(0, 11) == 0) begin
                item.command = ($urandom_range(0, 2) == 0) ? CMD_UNUSED
                             : (($urandom_range(0, 1) == 0) ? CMD_TOPIC : CMD_PAYLOAD);
            end
            push_request(item, 0);
        end
    endtask

    // Output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected byte: out_byte=%02h last=%0d too_long=%0d",
                             o_out_item.out_byte, o_out_item.last, o_out_item.too_long);
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_item.out_byte !== want.out_byte || o_out_item.last !== want.last
                    || o_out_item.too_long !== want.too_long) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("byte mismatch: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                                 want.out_byte, want.last, want.too_long,
                                 o_out_item.out_byte, o_out_item.last, o_out_item.too_long);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("mqtt_publish_framer: mismatch");
        $finish;
    end

    initial begin : byte_sink
        int unsigned hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
            hold = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : request_source
        logic [15:0] limits[6];
        int unsigned target;

        // empty topic and payload, QoS 0
        dir_rows.push_back('{mk_req(CMD_START, 8'h00, 16'd0, 16'd0, 2'd0, 1'b0), 4});
        want_byte(8'h30, 1'b0, 1'b0);
        want_byte(8'h02, 1'b0, 1'b0);
        want_byte(8'h00, 1'b0, 1'b0);
        want_byte(8'h00, 1'b1, 1'b0);
        // empty topic and payload, QoS 3 with retain: packet id carries last
        dir_rows.push_back('{mk_req(CMD_START, 8'hFF, 16'd0, 16'd0, 2'd3, 1'b1), 6});
        want_byte(8'h37, 1'b0, 1'b0);
        want_byte(8'h04, 1'b0, 1'b0);
        want_byte(8'h00, 1'b0, 1'b0);
        want_byte(8'h00, 1'b0, 1'b0);
        want_byte(8'h00, 1'b0, 1'b0);
        want_byte(8'h01, 1'b1, 1'b0);
        // complete packet with stray requests mixed in
        dir_rows.push_back('{mk_req(CMD_START, 8'h5A, 16'd2, 16'd3, 2'd1, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_TOPIC, 8'h00, 16'hFFFF, 16'hFFFF, 2'd3, 1'b1), 0});
        dir_rows.push_back('{mk_req(CMD_TOPIC, 8'hFF, 16'd0, 16'd0, 2'd0, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_TOPIC, 8'h11, 16'd0, 16'd0, 2'd0, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_PAYLOAD, 8'hA5, 16'd0, 16'd0, 2'd0, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_UNUSED, 8'hC3, 16'd7, 16'd7, 2'd2, 1'b1), 0});
        dir_rows.push_back('{mk_req(CMD_PAYLOAD, 8'h5A, 16'd0, 16'd0, 2'd0, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_PAYLOAD, 8'hFF, 16'd0, 16'd0, 2'd0, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_PAYLOAD, 8'h77, 16'd0, 16'd0, 2'd0, 1'b0), 0});
        // largest lengths: rejected, then bytes dropped until the next start
        dir_rows.push_back('{mk_req(CMD_START, 8'h00, 16'hFFFF, 16'hFFFF, 2'd2, 1'b1), 1});
        want_byte(8'h00, 1'b1, 1'b1);
        dir_rows.push_back('{mk_req(CMD_TOPIC, 8'h12, 16'd0, 16'd0, 2'd0, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_PAYLOAD, 8'h34, 16'd0, 16'd0, 2'd0, 1'b0), 0});
        // abandoned packets, one-, two- and three-byte remaining length
        dir_rows.push_back('{mk_req(CMD_START, 8'h00, 16'd100, 16'd20, 2'd0, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_TOPIC, 8'h41, 16'd0, 16'd0, 2'd0, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_START, 8'h00, 16'd0, 16'd200, 2'd2, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_PAYLOAD, 8'h01, 16'd0, 16'd0, 2'd0, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_START, 8'h00, 16'd0, 16'd16500, 2'd1, 1'b0), 0});
        // no payload: last topic byte carries last
        dir_rows.push_back('{mk_req(CMD_START, 8'h00, 16'd1, 16'd0, 2'd0, 1'b1), 0});
        dir_rows.push_back('{mk_req(CMD_TOPIC, 8'h80, 16'd0, 16'd0, 2'd0, 1'b0), 0});
        // one byte over the limit, exactly at it, and topic alone over it
        dir_rows.push_back('{mk_req(CMD_START, 8'h00, 16'd0, 16'd65530, 2'd0, 1'b0), 1});
        want_byte(8'h00, 1'b1, 1'b1);
        dir_rows.push_back('{mk_req(CMD_START, 8'h00, 16'd0, 16'd65529, 2'd0, 1'b0), 0});
        dir_rows.push_back('{mk_req(CMD_START, 8'h00, 16'hFFFF, 16'd0, 2'd0, 1'b0), 1});
        want_byte(8'h00, 1'b1, 1'b1);

        limits[0] = 16'd0;
        limits[1] = 16'd4;
        limits[2] = 16'd13;
        limits[3] = 16'($urandom_range(5, 40));
        limits[4] = 16'hFFFF;
        limits[5] = 16'($urandom_range(0, 65535));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) push_request(dir_rows[i].req, dir_rows[i].n_fixed);

        foreach (limits[p]) begin
            set_max_len(limits[p]);
            target = requests_sent + PHASE_REQUESTS;
            while (requests_sent < target) begin
                random_packet();
                if ($urandom_range(0, 39) == 0) settle_results();
            end
        end

        settle_results();
        if (mismatches == 0 && pending_bytes.size() == 0) begin
            $display("mqtt_publish_framer: match");
        end else begin
            $display("mqtt_publish_framer: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mpf_pkg.sv
rtl/mpf_front.sv
rtl/mpf_queue.sv
rtl/mpf_back.sv
rtl/mqtt_publish_framer.sv
dv/tb_top.sv
